FILE: hdl/tdp_pkg.sv
// shared constants and types for the trial division primality test
// no dependencies; imported by tdp_divider and the top level
package tdp_pkg;

  localparam int DATA_WIDTH = 32;
  localparam int IN_TDATA_W = ((DATA_WIDTH + 7) / 8) * 8;
  localparam int OUT_TDATA_W = 8;
  localparam int CNT_W = $clog2(DATA_WIDTH);

  typedef logic [DATA_WIDTH-1:0] word_t;

  // divider result, valid in the cycle that done is high
  typedef struct packed {
    logic  done;
    word_t quotient;
    word_t remainder;
  } div_result_t;

endpackage

FILE: hdl/trial_division_primality_test_top.sv
// top level of the trial division primality test: stream ports and sequencer
// depends on tdp_pkg and tdp_divider
//
// Takes one signed candidate per request and returns one is_prime flag per
// request. Negative values, zero and one are answered at once as not prime.
// Otherwise trial divisors 2, 3, ... are run through a shared radix-2 serial
// divider. Each divisor goes through a load step, DATA_WIDTH shift steps, and
// a step to read the remainder and restart. The walk stops at the first zero
// remainder (composite), or once the divisor exceeds the quotient, i.e. passes
// the square root (prime). For a 32-bit prime near the top of the range about
// 46340 divisors are tried. One item is in work at a time; a finished result
// waits in the output register while the next candidate is accepted.
module trial_division_primality_test_top
  import tdp_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [IN_TDATA_W-1:0]  s_tdata,   // candidate
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [OUT_TDATA_W-1:0] m_tdata    // is_prime, zero padded
);

  localparam logic [1:0] ST_IDLE = 2'd0;  // waiting for a candidate
  localparam logic [1:0] ST_DIV  = 2'd1;  // trial division running
  localparam logic [1:0] ST_FIN  = 2'd2;  // answer known, waiting for output slot

  logic [1:0]  state;
  word_t       n;        // candidate under test
  word_t       d;        // current trial divisor
  logic        verdict;  // answer held until the output slot frees
  logic        div_start;
  logic        out_bit;
  div_result_t div_res;
  word_t       cand;
  logic        accept;     // request taken this cycle
  logic        trivial;    // sign set, zero or one
  logic        past_root;  // divisor exceeds the quotient
  logic        div_more;   // remainder nonzero and still below the root
  logic        out_load;   // answer moves into the output register

  assign cand     = s_tdata[DATA_WIDTH-1:0];
  assign s_tready = (state == ST_IDLE);

  assign accept    = (state == ST_IDLE) && s_tvalid;
  assign trivial   = cand[DATA_WIDTH-1] || (cand <= word_t'(1));
  assign past_root = (d > div_res.quotient);
  assign div_more  = (state == ST_DIV) && div_res.done && !past_root &&
                     (div_res.remainder != '0);
  assign out_load  = (state == ST_FIN) && (!m_tvalid || m_tready);

  tdp_divider u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (n),
    .divisor  (d),
    .result   (div_res)
  );

  // sequencer: start a division on accept of a nontrivial candidate and after each non-final divisor
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      div_start <= 1'b0;
      m_tvalid  <= 1'b0;
    end else begin
      div_start <= (accept && !trivial) || div_more;
      // output slot free or being emptied this cycle
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            // sign set, zero or one: not prime, no division needed
            if (trivial) begin
              state <= ST_FIN;
            end else begin
              state <= ST_DIV;
            end
          end
        end
        ST_DIV: begin
          // past the square root, or divisor found
          if (div_res.done && (past_root || (div_res.remainder == '0))) begin
            state <= ST_FIN;
          end
        end
        ST_FIN: begin
          if (out_load) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && s_tvalid) begin
      n       <= cand;
      d       <= word_t'(2);
      verdict <= 1'b0;
    end else if (state == ST_DIV && div_res.done) begin
      if (d > div_res.quotient) begin
        verdict <= 1'b1;
      end else if (div_res.remainder != '0) begin
        d <= d + word_t'(1);
      end
    end
    if (state == ST_FIN && (!m_tvalid || m_tready)) begin
      out_bit <= verdict;
    end
  end

  assign m_tdata = {{(OUT_TDATA_W-1){1'b0}}, out_bit};

endmodule

FILE: hdl/tdp_divider.sv
// radix-2 restoring divider, one quotient bit per cycle
// depends on tdp_pkg
module tdp_divider
  import tdp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  word_t       dividend,
  input  word_t       divisor,
  output div_result_t result
);

  logic                  busy;
  logic                  done;
  logic [CNT_W-1:0]      cnt;
  word_t                 quo;
  word_t                 rem;
  word_t                 dsr;
  logic [DATA_WIDTH:0]   rem_shift;
  logic [DATA_WIDTH:0]   diff;
  logic                  ge;
  word_t                 quo_next;
  word_t                 rem_next;

  // shift in the next dividend bit and try a subtract
  always_comb begin
    rem_shift = {rem, quo[DATA_WIDTH-1]};
    diff      = rem_shift - {1'b0, dsr};
    ge        = rem_shift >= {1'b0, dsr};
    rem_next  = ge ? diff[DATA_WIDTH-1:0] : rem_shift[DATA_WIDTH-1:0];
    quo_next  = {quo[DATA_WIDTH-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(DATA_WIDTH - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
      dsr <= divisor;
    end else if (busy) begin
      quo <= quo_next;
      rem <= rem_next;
    end
  end

  assign result.done      = done;
  assign result.quotient  = quo;
  assign result.remainder = rem;

endmodule
